/* rtl/sprd_pkg.sv */
`timescale 1ns / 1ps

package sprd_pkg;

    // item kinds on the input channel
    localparam logic [1:0] ACT_DECODE    = 2'd0;
    localparam logic [1:0] ACT_WR_PATTERN = 2'd1;
    localparam logic [1:0] ACT_WR_PALETTE = 2'd2;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPRITE_TALL    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_SELECT = 2'd1;

    localparam int PAT_ADDR_W = 13;
    localparam int PAL_ADDR_W = 5;

    typedef logic [1:0]            action_t;
    typedef logic [7:0]            byte_t;
    typedef logic [PAT_ADDR_W-1:0] pat_addr_t;
    typedef logic [PAL_ADDR_W-1:0] pal_addr_t;
    typedef logic [5:0]            color_t;
    typedef logic [3:0]            row_t;

endpackage

/* rtl/sprite_pattern_row_decoder.sv */
`timescale 1ns / 1ps

// Sprite pattern row decoder. Write beats (pattern byte, palette byte) and
// ignored beats (action 3) are taken in the idle state and leave it idle. A
// decode beat first copies the three colors of its sprite palette out of the
// palette memory, then takes each sprite row through the states LO, HI and
// FORM, since both bit-plane bytes of a row come through the single read port
// of the pattern memory one after the other; FORM waits while the output side
// stalls. in_ready is low for the whole decode; the last row may still wait in
// the output register while the next beat is taken. Both memories are
// undefined until written and need no clearing after reset. Configuration
// writes are taken in any cycle and are meant for an idle block.
module sprite_pattern_row_decoder (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sprd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic                               cfg_data,
    // input item channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  sprd_pkg::action_t                  action,
    input  sprd_pkg::byte_t                    tile_index,
    input  sprd_pkg::byte_t                    attributes,
    input  sprd_pkg::pat_addr_t                mem_address,
    input  sprd_pkg::byte_t                    mem_data,
    // row result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output sprd_pkg::row_t                     row_number,
    output sprd_pkg::color_t                   pixel_0,
    output sprd_pkg::color_t                   pixel_1,
    output sprd_pkg::color_t                   pixel_2,
    output sprd_pkg::color_t                   pixel_3,
    output sprd_pkg::color_t                   pixel_4,
    output sprd_pkg::color_t                   pixel_5,
    output sprd_pkg::color_t                   pixel_6,
    output sprd_pkg::color_t                   pixel_7,
    output sprd_pkg::byte_t                    opaque_mask,
    output logic                               last_row
);
    import sprd_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a beat
    localparam logic [2:0] ST_PAL  = 3'd1;  // copying sprite palette colors
    localparam logic [2:0] ST_LO   = 3'd2;  // low plane read issued
    localparam logic [2:0] ST_HI   = 3'd3;  // high plane read issued, low captured
    localparam logic [2:0] ST_FORM = 3'd4;  // build the row into the output register

    // configuration registers
    logic sprite_tall_reg;
    logic pattern_select_reg;

    // sequencer
    logic [2:0] state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;     // palette copy step
    row_t       y_reg, y_next;         // output row

    // sprite parameters latched when the decode beat is taken
    logic       tall_reg;
    logic       hflip_reg;
    logic       vflip_reg;
    logic [1:0] pal_reg;
    logic       base_reg;              // pattern half, address bit 12
    byte_t      tbase_reg;             // top tile number

    // the three colors of the sprite palette; entry 0 is transparent
    color_t     color_reg [4];

    // memories, registered read
    byte_t      pattern_mem [1 << PAT_ADDR_W];
    color_t     palette_mem [1 << PAL_ADDR_W];
    pat_addr_t  pat_raddr;
    byte_t      pat_rdata_reg;
    pal_addr_t  pal_raddr;
    color_t     pal_rdata_reg;
    byte_t      lo_reg;

    // output register
    logic       out_valid_reg;
    row_t       row_reg;
    color_t     pix_reg [8];
    byte_t      mask_reg;
    logic       last_reg;

    logic       in_fire;
    logic       load_out;
    row_t       last_y;
    row_t       sy;
    byte_t      tile_sum;
    pat_addr_t  row_addr;
    color_t     pix [8];
    byte_t      mask;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sprite_tall_reg    <= 1'b0;
            pattern_select_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SPRITE_TALL:    sprite_tall_reg    <= cfg_data;
                CFG_PATTERN_SELECT: pattern_select_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // row address: vertical flip spans all rows, tile pair in tall mode
    assign last_y   = tall_reg ? 4'd15 : 4'd7;
    assign sy       = vflip_reg ? (last_y - y_reg) : y_reg;
    assign tile_sum = tbase_reg + {7'd0, sy[3]};
    assign row_addr = pat_addr_t'({base_reg, 12'd0} + {1'b0, tile_sum, 4'd0}
                                  + {9'd0, 1'b0, sy[2:0]});

    // low plane at the row address, high plane 8 bytes later
    always_comb
    begin
        if (state_reg == ST_HI)
            pat_raddr = pat_addr_t'(row_addr + 13'd8);
        else
            pat_raddr = row_addr;
    end

    // sprite palette p = pal + 4 gives entries {1, pal, color}
    assign pal_raddr = {1'b1, pal_reg, 2'(cnt_reg + 2'd1)};

    always_ff @(posedge clk)
    begin
        if (in_fire && action == ACT_WR_PATTERN)
            pattern_mem[mem_address] <= mem_data;
        // read register keeps the high plane while a finished row waits
        if (state_reg == ST_LO || state_reg == ST_HI)
            pat_rdata_reg <= pattern_mem[pat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && action == ACT_WR_PALETTE)
            palette_mem[mem_address[PAL_ADDR_W-1:0]] <= mem_data[5:0];
        pal_rdata_reg <= palette_mem[pal_raddr];
    end

    // pixel build: lo_reg holds the low plane, the read register the high plane
    always_comb
    begin
        logic [2:0] bit_sel;
        logic [1:0] c;
        mask = '0;
        for (int x = 0; x < 8; x++)
        begin
            bit_sel = hflip_reg ? 3'(x) : 3'(7 - x);
            c       = {pat_rdata_reg[bit_sel], lo_reg[bit_sel]};
            pix[x]  = color_reg[c];
            mask[x] = (c != 2'd0);
        end
    end

    assign load_out = (state_reg == ST_FORM) && (!out_valid_reg || out_ready);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        y_next     = y_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && action == ACT_DECODE)
                begin
                    state_next = ST_PAL;
                    cnt_next   = 2'd0;
                    y_next     = 4'd0;
                end
            end
            ST_PAL:
            begin
                cnt_next = 2'(cnt_reg + 2'd1);
                if (cnt_reg == 2'd3)
                    state_next = ST_LO;
            end
            ST_LO:
                state_next = ST_HI;
            ST_HI:
                state_next = ST_FORM;
            ST_FORM:
            begin
                if (load_out)
                begin
                    if (y_reg == last_y)
                        state_next = ST_IDLE;
                    else
                    begin
                        state_next = ST_LO;
                        y_next     = 4'(y_reg + 4'd1);
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 2'd0;
            y_reg     <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            y_reg     <= y_next;
        end
    end

    // sprite latch, palette copy, low plane capture
    always_ff @(posedge clk)
    begin
        if (in_fire && action == ACT_DECODE)
        begin
            tall_reg     <= sprite_tall_reg;
            hflip_reg    <= attributes[6];
            vflip_reg    <= attributes[7];
            pal_reg      <= attributes[1:0];
            color_reg[0] <= '0;
            if (sprite_tall_reg)
            begin
                base_reg  <= tile_index[0];
                tbase_reg <= {tile_index[7:1], 1'b0};
            end
            else
            begin
                base_reg  <= pattern_select_reg;
                tbase_reg <= tile_index;
            end
        end
        // color of step n-1 arrives at step n
        if (state_reg == ST_PAL && cnt_reg != 2'd0)
            color_reg[cnt_reg] <= pal_rdata_reg;
        if (state_reg == ST_HI)
            lo_reg <= pat_rdata_reg;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            row_reg  <= y_reg;
            pix_reg  <= pix;
            mask_reg <= mask;
            last_reg <= (y_reg == last_y);
        end
    end

    assign out_valid   = out_valid_reg;
    assign row_number  = row_reg;
    assign pixel_0     = pix_reg[0];
    assign pixel_1     = pix_reg[1];
    assign pixel_2     = pix_reg[2];
    assign pixel_3     = pix_reg[3];
    assign pixel_4     = pix_reg[4];
    assign pixel_5     = pix_reg[5];
    assign pixel_6     = pix_reg[6];
    assign pixel_7     = pix_reg[7];
    assign opaque_mask = mask_reg;
    assign last_row    = last_reg;

endmodule

/* rtl/sprd_checker.sv */
`timescale 1ns / 1ps

module sprd_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_ready,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  sprd_pkg::row_t                     row_number,
    input  sprd_pkg::color_t                   pixel_0,
    input  sprd_pkg::color_t                   pixel_3,
    input  sprd_pkg::color_t                   pixel_7,
    input  sprd_pkg::byte_t                    opaque_mask,
    input  logic                               last_row
);
    import sprd_pkg::*;

    // a stalled row beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(row_number)
            && $stable(opaque_mask) && $stable(last_row) && $stable(pixel_0))
        else $error("row beat changed while stalled");

    // more rows to come means the decode is still busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_row |-> !in_ready)
        else $error("input taken in the middle of a sprite");

    // transparent pixels carry color zero
    a_transparent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (opaque_mask[0] || pixel_0 == 6'd0)
            && (opaque_mask[3] || pixel_3 == 6'd0)
            && (opaque_mask[7] || pixel_7 == 6'd0))
        else $error("transparent pixel with nonzero color");

    // a sprite ends on row 7 or row 15
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_row |-> (row_number == 4'd7 || row_number == 4'd15))
        else $error("last row at an odd row number");

endmodule

bind sprite_pattern_row_decoder sprd_checker u_sprd_checker (.*);

/* test/tb_sprite_pattern_row_decoder.sv */
`timescale 1ns / 1ps

module tb_sprite_pattern_row_decoder;

    import sprd_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int RESET_CYCLES = 10;
    // longer than the longest decode (8x16), so this covers anything still in flight
    localparam int SETTLE_CYCLES = 64;
    localparam int MAX_GAP = 18;
    localparam int PHASES = 5;
    localparam int BEATS_PER_PHASE = 36;
    // action code that the block drops on the floor
    localparam action_t ACT_UNUSED = 2'd3;

    localparam pat_addr_t HIGH_HALF = 13'h1000;
    localparam pat_addr_t PLANE_GAP = 13'h0008;

    // register settings walked by the random part, one bit per phase
    localparam bit [PHASES-1:0] PHASE_TALL = 5'b10101;
    localparam bit [PHASES-1:0] PHASE_HIGH = 5'b10110;

    typedef enum logic {STEP_BEAT, STEP_REG} step_kind_t;

    // one row of the directed table, also reused to carry random beats
    typedef struct packed {
        step_kind_t                kind;
        action_t                   action;
        byte_t                     tile;
        byte_t                     attr;
        pat_addr_t                 addr;
        byte_t                     data;
        logic [CFG_INDEX_W-1:0]    reg_index;
        logic                      reg_value;
        logic                      typed;
        color_t                    exp_pix;
        byte_t                     exp_mask;
    } stim_step_t;

    // one decoded sprite row as seen on the result channel
    typedef struct packed {
        row_t           row;
        color_t [7:0]   pix;
        byte_t          mask;
        logic           last;
    } sprite_row_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic                     cfg_data;

    logic        in_valid;
    logic        in_ready;
    action_t     action;
    byte_t       tile_index;
    byte_t       attributes;
    pat_addr_t   mem_address;
    byte_t       mem_data;

    logic        out_valid;
    logic        out_ready;
    row_t        row_number;
    color_t      pixel_0;
    color_t      pixel_1;
    color_t      pixel_2;
    color_t      pixel_3;
    color_t      pixel_4;
    color_t      pixel_5;
    color_t      pixel_6;
    color_t      pixel_7;
    byte_t       opaque_mask;
    logic        last_row;

    // shadow copies of the block's memories and registers
    byte_t   pattern_shadow [0:8191];
    bit      pattern_written [0:8191];
    color_t  palette_shadow [0:31];
    bit      tall_mode;
    bit      high_table;

    // rows still owed by the block, oldest first
    sprite_row_t pending_rows[$];

    int  mismatch_count = 0;
    int  beats_sent = 0;
    // set while in_valid was left high after the last accepted beat
    bit  valid_up = 1'b0;
    // burst flags switch idling off for a stretch on either side
    bit  in_burst = 1'b0;
    bit  out_burst = 1'b0;

    sprite_pattern_row_decoder u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .tile_index  (tile_index),
        .attributes  (attributes),
        .mem_address (mem_address),
        .mem_data    (mem_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .row_number  (row_number),
        .pixel_0     (pixel_0),
        .pixel_1     (pixel_1),
        .pixel_2     (pixel_2),
        .pixel_3     (pixel_3),
        .pixel_4     (pixel_4),
        .pixel_5     (pixel_5),
        .pixel_6     (pixel_6),
        .pixel_7     (pixel_7),
        .opaque_mask (opaque_mask),
        .last_row    (last_row)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic report_error(input string msg);
        $display("[%0t] %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic stim_step_t make_beat(input action_t a, input byte_t t, input byte_t at,
                                             input pat_addr_t ad, input byte_t d);
        stim_step_t s;
        s = '0;
        s.kind = STEP_BEAT;
        s.action = a;
        s.tile = t;
        s.attr = at;
        s.addr = ad;
        s.data = d;
        return s;
    endfunction

    // decode beat whose rows are all the same color and mask, known up front
    function automatic stim_step_t make_typed(input byte_t t, input byte_t at, input pat_addr_t ad,
                                              input byte_t d, input color_t pix, input byte_t mask);
        stim_step_t s;
        s = make_beat(ACT_DECODE, t, at, ad, d);
        s.typed = 1'b1;
        s.exp_pix = pix;
        s.exp_mask = mask;
        return s;
    endfunction

    function automatic stim_step_t make_reg_write(input logic [CFG_INDEX_W-1:0] idx, input logic v);
        stim_step_t s;
        s = '0;
        s.kind = STEP_REG;
        s.reg_index = idx;
        s.reg_value = v;
        return s;
    endfunction

    // random byte and random address
    function automatic byte_t rand_byte();
        return byte_t'($urandom);
    endfunction

    function automatic pat_addr_t rand_addr();
        return pat_addr_t'($urandom);
    endfunction

    // address of the low bit-plane byte for sprite row sy under the current mode
    function automatic pat_addr_t plane_addr(input byte_t tile, input int sy);
        pat_addr_t half;
        byte_t     t;
        if (tall_mode)
        begin
            // 8x16: tile bit 0 picks the half, rows 8..15 come from the odd tile
            half = tile[0] ? HIGH_HALF : '0;
            t = {tile[7:1], 1'b0} + byte_t'(sy >> 3);
        end
        else
        begin
            half = high_table ? HIGH_HALF : '0;
            t = tile;
        end
        return half + {1'b0, t, 4'b0000} + pat_addr_t'(sy & 7);
    endfunction

    function automatic bit sprite_loaded(input byte_t tile);
        int        sy;
        pat_addr_t ad;
        for (sy = 0; sy < (tall_mode ? 16 : 8); sy++)
        begin
            ad = plane_addr(tile, sy);
            if (!pattern_written[ad] || !pattern_written[ad + PLANE_GAP])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // work out every row of a sprite decode from the shadow memories
    function automatic void predict_sprite_rows(input byte_t tile, input byte_t attr);
        int          rows;
        int          y;
        int          sy;
        int          x;
        int          b;
        logic [2:0]  pal;
        logic [1:0]  c;
        pat_addr_t   ad;
        byte_t       lo;
        byte_t       hi;
        sprite_row_t r;
        rows = tall_mode ? 16 : 8;
        // sprite palettes are 4..7, so the entry index is {1, attr[1:0], color}
        pal = {1'b1, attr[1:0]};
        for (y = 0; y < rows; y++)
        begin
            // vertical flip runs over the whole sprite, both tiles in 8x16
            sy = attr[7] ? rows - 1 - y : y;
            ad = plane_addr(tile, sy);
            lo = pattern_shadow[ad];
            hi = pattern_shadow[ad + PLANE_GAP];
            r = '0;
            r.row = row_t'(y);
            for (x = 0; x < 8; x++)
            begin
                // pixel 0 is the msb unless flipped horizontally
                b = attr[6] ? x : 7 - x;
                c = {hi[b], lo[b]};
                if (c != 2'd0)
                begin
                    r.pix[x] = palette_shadow[{pal, c}];
                    r.mask[x] = 1'b1;
                end
            end
            r.last = (y == rows - 1);
            pending_rows.push_back(r);
        end
    endfunction

    // drive one input beat, wait for the handshake, then update the shadows
    task automatic send_step(input stim_step_t s);
        int          gap;
        int          y;
        sprite_row_t r;
        gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 15) == 0)
            in_burst = !in_burst;
        if (gap > 0)
        begin
            if (valid_up)
            begin
                in_valid <= 1'b0;
                valid_up = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= s.action;
        tile_index  <= s.tile;
        attributes  <= s.attr;
        mem_address <= s.addr;
        mem_data    <= s.data;
        valid_up = 1'b1;
        do @(posedge clk); while (!in_ready);
        case (s.action)
            ACT_WR_PATTERN:
            begin
                pattern_shadow[s.addr] = s.data;
                pattern_written[s.addr] = 1'b1;
            end
            ACT_WR_PALETTE: palette_shadow[s.addr[PAL_ADDR_W-1:0]] = s.data[5:0];
            ACT_DECODE:
            begin
                if (s.typed)
                begin
                    for (y = 0; y < (tall_mode ? 16 : 8); y++)
                    begin
                        r.row = row_t'(y);
                        r.pix = {8{s.exp_pix}};
                        r.mask = s.exp_mask;
                        r.last = (y == (tall_mode ? 15 : 7));
                        pending_rows.push_back(r);
                    end
                end
                else
                begin
                    predict_sprite_rows(s.tile, s.attr);
                end
            end
            default: ;
        endcase
        if (s.action != ACT_UNUSED)
            beats_sent++;
    endtask

    // fill every missing pattern byte of a sprite with random content
    task automatic load_sprite(input byte_t tile);
        int        sy;
        int        plane;
        pat_addr_t ad;
        for (sy = 0; sy < (tall_mode ? 16 : 8); sy++)
        begin
            for (plane = 0; plane < 2; plane++)
            begin
                ad = plane_addr(tile, sy) + (plane != 0 ? PLANE_GAP : '0);
                if (!pattern_written[ad])
                    send_step(make_beat(ACT_WR_PATTERN, rand_byte(), rand_byte(), ad,
                                        rand_byte()));
            end
        end
    endtask

    // stop feeding, let every owed row come out, then give the block a pause
    task automatic settle();
        if (valid_up)
        begin
            in_valid <= 1'b0;
            valid_up = 1'b0;
        end
        while (pending_rows.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_SPRITE_TALL:    tall_mode = v;
            CFG_PATTERN_SELECT: high_table = v;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // result side: random stall before each beat, with burst stretches
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = out_burst ? 0 : $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 15) == 0)
                out_burst = !out_burst;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // compare every accepted row beat against the oldest owed row
    always @(posedge clk)
    begin : row_check
        sprite_row_t got;
        sprite_row_t want;
        int          x;
        if (rst_n && out_valid && out_ready)
        begin
            got.row  = row_number;
            got.pix  = {pixel_7, pixel_6, pixel_5, pixel_4, pixel_3, pixel_2, pixel_1, pixel_0};
            got.mask = opaque_mask;
            got.last = last_row;
            if (pending_rows.size() == 0)
            begin
                report_error($sformatf("row beat %0d with nothing owed", got.row));
            end
            else
            begin
                want = pending_rows.pop_front();
                if (got.row !== want.row)
                    report_error($sformatf("row_number got %0d want %0d", got.row, want.row));
                for (x = 0; x < 8; x++)
                begin
                    if (got.pix[x] !== want.pix[x])
                        report_error($sformatf("row %0d pixel_%0d got %0d want %0d",
                                               want.row, x, got.pix[x], want.pix[x]));
                end
                if (got.mask !== want.mask)
                    report_error($sformatf("row %0d opaque_mask got %h want %h",
                                           want.row, got.mask, want.mask));
                if (got.last !== want.last)
                    report_error($sformatf("row %0d last_row got %0d want %0d",
                                           want.row, got.last, want.last));
            end
        end
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        stim_step_t  directed_steps[$];
        stim_step_t  s;
        byte_t       tile_pool[$];
        int          i;
        int          p;
        int          start;
        int          pick;
        byte_t       tile;
        pat_addr_t   ad;

        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = 1'b0;
        in_valid    = 1'b0;
        action      = ACT_DECODE;
        tile_index  = '0;
        attributes  = '0;
        mem_address = '0;
        mem_data    = '0;
        tall_mode   = 1'b0;
        high_table  = 1'b0;
        for (i = 0; i < 8192; i++)
        begin
            pattern_shadow[i] = '0;
            pattern_written[i] = 1'b0;
        end
        for (i = 0; i < 32; i++)
            palette_shadow[i] = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every sprite palette color (palettes 4..7, colors 1..3) gets a value,
        // so no decode can ever use an unwritten palette entry
        for (i = 16; i < 32; i++)
        begin
            if (i % 4 != 0)
                send_step(make_beat(ACT_WR_PALETTE, rand_byte(), rand_byte(),
                                    {8'($urandom_range(0, 255)), 5'(i)}, rand_byte()));
        end

        // pattern preload for the directed table:
        //   tiles 0 and 1 solid color 3, tile at 0x1fe0 color 1 only,
        //   tile at 0x1ff0 fully transparent, random tiles at 0x0810 and 0x1800
        for (i = 0; i < 32; i++)
            send_step(make_beat(ACT_WR_PATTERN, rand_byte(), rand_byte(), 13'(i), 8'hFF));
        for (i = 0; i < 16; i++)
            send_step(make_beat(ACT_WR_PATTERN, rand_byte(), rand_byte(), 13'h1FE0 + 13'(i),
                                i < 8 ? 8'hFF : 8'h00));
        for (i = 0; i < 16; i++)
            send_step(make_beat(ACT_WR_PATTERN, rand_byte(), rand_byte(), 13'h1FF0 + 13'(i),
                                8'h00));
        for (i = 0; i < 16; i++)
            send_step(make_beat(ACT_WR_PATTERN, rand_byte(), rand_byte(), 13'h0810 + 13'(i),
                                rand_byte()));
        for (i = 0; i < 32; i++)
            send_step(make_beat(ACT_WR_PATTERN, rand_byte(), rand_byte(), 13'h1800 + 13'(i),
                                rand_byte()));

        // directed table; typed rows carry a color that fills the whole sprite
        // palette 4 color 3 := 0x2a, palette 7 color 3 := 0x3f (data bits 7:6 dropped)
        directed_steps.push_back(make_beat(ACT_WR_PALETTE, 8'h00, 8'h00, 13'h0013, 8'h2A));
        directed_steps.push_back(make_beat(ACT_WR_PALETTE, 8'hFF, 8'hFF, 13'h1FFF, 8'hFF));
        // palette 5 color 3 := 0, giving opaque pixels of color index zero
        directed_steps.push_back(make_beat(ACT_WR_PALETTE, 8'h00, 8'h00, 13'h1FF7, 8'hC0));
        directed_steps.push_back(make_beat(ACT_WR_PALETTE, 8'h00, 8'h00, 13'h0000, 8'h00));
        // reset mode: 8x8, low half
        directed_steps.push_back(make_typed(8'h00, 8'h00, 13'h0000, 8'h00, 6'h2A, 8'hFF));
        directed_steps.push_back(make_typed(8'h00, 8'hC0, 13'h0000, 8'h00, 6'h2A, 8'hFF));
        directed_steps.push_back(make_typed(8'h00, 8'hFF, 13'h1FFF, 8'hFF, 6'h3F, 8'hFF));
        // attribute bits 5:2 set, must not matter
        directed_steps.push_back(make_typed(8'h00, 8'h3D, 13'h0AAA, 8'h55, 6'h00, 8'hFF));
        // unused action with every bit high: no rows, no state change
        directed_steps.push_back(make_beat(ACT_UNUSED, 8'hFF, 8'hFF, 13'h1FFF, 8'hFF));
        directed_steps.push_back(make_beat(ACT_DECODE, 8'h81, 8'h00, 13'h0000, 8'h00));
        directed_steps.push_back(make_beat(ACT_DECODE, 8'h81, 8'h40, 13'h0000, 8'h00));
        directed_steps.push_back(make_beat(ACT_DECODE, 8'h81, 8'h82, 13'h0000, 8'h00));
        directed_steps.push_back(make_reg_write(CFG_PATTERN_SELECT, 1'b1));
        directed_steps.push_back(make_typed(8'hFF, 8'h00, 13'h0000, 8'h00, 6'h00, 8'h00));
        directed_steps.push_back(make_beat(ACT_DECODE, 8'h81, 8'hC3, 13'h0000, 8'h00));
        // 8x16: half from tile bit 0, table select ignored
        directed_steps.push_back(make_reg_write(CFG_SPRITE_TALL, 1'b1));
        directed_steps.push_back(make_beat(ACT_DECODE, 8'hFF, 8'h00, 13'h0000, 8'h00));
        directed_steps.push_back(make_beat(ACT_DECODE, 8'hFF, 8'h80, 13'h0000, 8'h00));
        directed_steps.push_back(make_typed(8'h00, 8'h00, 13'h0000, 8'h00, 6'h2A, 8'hFF));
        directed_steps.push_back(make_beat(ACT_DECODE, 8'h81, 8'h41, 13'h0000, 8'h00));
        directed_steps.push_back(make_reg_write(CFG_SPRITE_TALL, 1'b0));
        directed_steps.push_back(make_reg_write(CFG_PATTERN_SELECT, 1'b0));
        // punch a hole in tile 0 row 0, then look at it
        directed_steps.push_back(make_beat(ACT_WR_PATTERN, 8'hFF, 8'hFF, 13'h0000, 8'h00));
        directed_steps.push_back(make_beat(ACT_DECODE, 8'h00, 8'h00, 13'h0000, 8'h00));
        directed_steps.push_back(make_beat(ACT_WR_PATTERN, 8'h00, 8'h00, 13'h1FFF, 8'hFF));

        for (i = 0; i < directed_steps.size(); i++)
        begin
            s = directed_steps[i];
            if (s.kind == STEP_REG)
            begin
                settle();
                write_register(s.reg_index, s.reg_value);
            end
            else
            begin
                send_step(s);
            end
        end

        // random part: a small pool of sprites that get decoded over and over,
        // plus fresh tiles, rewrites of live sprite bytes, stray writes and noise
        tile_pool.push_back(8'h00);
        tile_pool.push_back(8'h81);
        tile_pool.push_back(8'hFF);
        for (i = 0; i < 5; i++)
            tile_pool.push_back(rand_byte());

        for (p = 0; p < PHASES; p++)
        begin
            settle();
            write_register(CFG_SPRITE_TALL, PHASE_TALL[p]);
            write_register(CFG_PATTERN_SELECT, PHASE_HIGH[p]);
            start = beats_sent;
            while (beats_sent - start < BEATS_PER_PHASE)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    if (pick < 6)
                    begin
                        tile = rand_byte();
                        tile_pool.push_back(tile);
                    end
                    else
                    begin
                        tile = tile_pool[$urandom_range(0, tile_pool.size() - 1)];
                    end
                    if (!sprite_loaded(tile))
                        load_sprite(tile);
                    send_step(make_beat(ACT_DECODE, tile, rand_byte(), rand_addr(),
                                        rand_byte()));
                end
                else if (pick < 62)
                begin
                    send_step(make_beat(ACT_WR_PATTERN, rand_byte(), rand_byte(), rand_addr(),
                                        rand_byte()));
                end
                else if (pick < 76)
                begin
                    // change content of a pool sprite so its next decode differs
                    tile = tile_pool[$urandom_range(0, tile_pool.size() - 1)];
                    ad = plane_addr(tile, $urandom_range(0, tall_mode ? 15 : 7));
                    if ($urandom_range(0, 1) != 0)
                        ad = ad + PLANE_GAP;
                    send_step(make_beat(ACT_WR_PATTERN, rand_byte(), rand_byte(), ad,
                                        rand_byte()));
                end
                else if (pick < 90)
                begin
                    send_step(make_beat(ACT_WR_PALETTE, rand_byte(), rand_byte(), rand_addr(),
                                        rand_byte()));
                end
                else
                begin
                    send_step(make_beat(ACT_UNUSED, rand_byte(), rand_byte(), rand_addr(),
                                        rand_byte()));
                end
            end
        end

        settle();
        if (pending_rows.size() != 0)
            report_error($sformatf("%0d rows never came out", pending_rows.size()));

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
